[hw/rtl/tdp_pkg.sv]
package tdp_pkg;

  // Width of the candidate and echo ports, fixed by the interface
  localparam int CAND_WIDTH = 32;

  // Remainder unit back to the sequencer
  typedef struct packed {
    logic done;  // one-cycle pulse after the last quotient bit
    logic zero;  // remainder is zero, valid with done
  } tdp_div_rsp_t;

  // Sequencer result towards the output register
  typedef struct packed {
    logic valid;
    logic flag;
  } tdp_res_t;

endpackage

[hw/rtl/tdp_rem.sv]
module tdp_rem import tdp_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output tdp_div_rsp_t rsp
);

  localparam int CNT_W = $clog2(W);
  localparam logic [CNT_W-1:0] TOP_BIT = CNT_W'(W - 1);

  logic [W-1:0]     rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [W:0]       trial;
  logic [W:0]       diff;
  logic [W-1:0]     rem_next;

  // Restoring division, one quotient bit per cycle, MSB first
  always_comb begin
    trial = {rem, dividend[cnt]};
    diff  = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      rem_next = diff[W-1:0];
    end else begin
      rem_next = trial[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      rem  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= TOP_BIT;
        rem  <= '0;
      end else if (busy) begin
        rem <= rem_next;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.zero = (rem == '0);

endmodule

[hw/rtl/tdp_ctrl.sv]
module tdp_ctrl import tdp_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] value,
  input  logic         res_ack,
  output logic         idle,
  output tdp_res_t     res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_DONE
  } state_t;

  state_t       state;
  logic [W-1:0] v;
  logic [W-1:0] d;
  logic [W:0]   sq;    // d*d, kept by increments
  logic         flag;
  logic         div_start;
  tdp_div_rsp_t div_rsp;
  logic [W:0]   sq_step;

  assign div_start = (state == S_CHECK) && (sq <= {1'b0, v});
  assign sq_step   = {d[W-2:0], 2'b00};

  tdp_rem #(.W(W)) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (v),
    .divisor  (d),
    .rsp      (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      flag  <= 1'b0;
      v     <= '0;
      d     <= '0;
      sq    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            v  <= value;
            d  <= W'(3);
            sq <= (W+1)'(9);
            if (value[W-1] || value <= W'(1)) begin
              flag  <= 1'b0;
              state <= S_DONE;
            end else if (value == W'(2)) begin
              flag  <= 1'b1;
              state <= S_DONE;
            end else if (!value[0]) begin
              flag  <= 1'b0;
              state <= S_DONE;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (div_start) begin
            state <= S_DIV;
          end else begin
            // divisor squared has passed the value: no factor found
            flag  <= 1'b1;
            state <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (div_rsp.zero) begin
              flag  <= 1'b0;
              state <= S_DONE;
            end else begin
              // (d+2)^2 = d^2 + 4d + 4
              sq    <= sq + sq_step + (W+1)'(4);
              d     <= d + W'(2);
              state <= S_CHECK;
            end
          end
        end
        S_DONE: begin
          if (res_ack) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign idle      = (state == S_IDLE);
  assign res.valid = (state == S_DONE);
  assign res.flag  = flag;

endmodule

[hw/rtl/trial_division_prime_test_top.sv]
// Trial-division primality test. Each transfer on the input channel carries one
// signed integer (the low VALUE_WIDTH bits of candidate, two's complement); one
// result comes back with the value, sign-extended to 32 bits, and prime_flag.
// Values of 1 or less and even values (2 is prime) are settled without a division.
// Odd values are tested against divisors 3, 5, 7, ... while d*d <= value,
// using a single restoring remainder unit that produces one bit per cycle.
// The worst case is a prime near the top of the range, with about sqrt(value)/2
// divisors to be tried.
// One item is in work at a time; in_stall stays high until its result has moved
// into the output register, which can hold a result while the next item runs.
module trial_division_prime_test_top import tdp_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [CAND_WIDTH-1:0] candidate,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [CAND_WIDTH-1:0] candidate_echo,
  output logic                         prime_flag
);

  localparam int W = VALUE_WIDTH;

  logic [W-1:0]          value;
  logic [CAND_WIDTH-1:0] echo_in;
  logic [CAND_WIDTH-1:0] echo_hold;
  logic                  in_xfer;
  logic                  ctrl_idle;
  logic                  res_ack;
  tdp_res_t              res;

  generate
    if (W <= CAND_WIDTH) begin : g_narrow
      assign value = candidate[W-1:0];
      if (W < CAND_WIDTH) begin : g_ext
        assign echo_in = {{(CAND_WIDTH-W){value[W-1]}}, value};
      end else begin : g_full
        assign echo_in = value;
      end
    end else begin : g_wide
      // bits above the port are zero, so the value is never negative
      assign value   = {{(W-CAND_WIDTH){1'b0}}, candidate};
      assign echo_in = value[CAND_WIDTH-1:0];
    end
  endgenerate

  assign in_stall = !ctrl_idle;
  assign in_xfer  = in_valid && ctrl_idle;
  assign res_ack  = res.valid && (!out_valid || !out_stall);

  tdp_ctrl #(.W(W)) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (in_xfer),
    .value   (value),
    .res_ack (res_ack),
    .idle    (ctrl_idle),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      echo_hold <= echo_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      prime_flag     <= 1'b0;
      candidate_echo <= '0;
    end else begin
      if (res_ack) begin
        out_valid      <= 1'b1;
        prime_flag     <= res.flag;
        candidate_echo <= echo_hold;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
